@@ hw/rtl/prlr_pkg.sv @@
package prlr_pkg;

  localparam int KEYWORD_MAX_DEF = 9;
  localparam int SCHEME_SKIP_DEF = 7;

  localparam int PORT_DEFAULT = 80;
  localparam int PORT_MAX     = 65535;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // register indexes, one 64-bit slot each
  localparam logic [1:0] REG_KW_FIRST  = 2'd0;
  localparam logic [1:0] REG_KW_NINTH  = 2'd1;
  localparam logic [1:0] REG_KW_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    ROLE_METHOD = 3'd0,
    ROLE_SEP    = 3'd1,
    ROLE_SCHEME = 3'd2,
    ROLE_HOST   = 3'd3,
    ROLE_PORT   = 3'd4,
    ROLE_REST   = 3'd5
  } role_t;

  typedef struct packed {
    logic [7:0]  rewritten_byte;
    role_t       byte_role;
    logic [15:0] port_number;
  } parse_res_t;

  typedef struct packed {
    logic [63:0] first_bytes;
    logic [7:0]  ninth_byte;
    logic [3:0]  length;
  } kw_cfg_t;

endpackage

@@ hw/rtl/prlr_line_parser.sv @@
module prlr_line_parser import prlr_pkg::*; #(
  parameter int SCHEME_SKIP = SCHEME_SKIP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last,
  output parse_res_t res
);

  localparam int SKIP_W = (SCHEME_SKIP < 1) ? 1 : $clog2(SCHEME_SKIP + 1);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SCHEME,
    PH_HOST,
    PH_PORT,
    PH_REST
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [15:0]         port_r, port_nxt;
  logic                seen_r, seen_nxt;

  logic [15:0] port_base;
  logic [19:0] port_sum;
  logic        is_digit;

  assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign port_base = seen_r ? port_r : 16'd0;
  assign port_sum  = ({4'd0, port_base} << 3) + ({4'd0, port_base} << 1)
                     + 20'(data_byte - CHAR_ZERO);

  always_comb begin
    phase_nxt          = phase_r;
    skip_nxt           = skip_r;
    port_nxt           = port_r;
    seen_nxt           = seen_r;
    res.rewritten_byte = data_byte;
    res.byte_role      = ROLE_REST;
    case (phase_r)
      PH_METHOD: begin
        if (data_byte == CHAR_SPACE) begin
          res.byte_role = ROLE_SEP;
          skip_nxt      = '0;
          phase_nxt     = (SCHEME_SKIP == 0) ? PH_HOST : PH_SCHEME;
        end else begin
          res.byte_role = ROLE_METHOD;
        end
      end
      PH_SCHEME: begin
        res.byte_role      = ROLE_SCHEME;
        res.rewritten_byte = CHAR_SPACE;
        if (skip_r == SKIP_W'(SCHEME_SKIP - 1)) begin
          skip_nxt  = '0;
          phase_nxt = PH_HOST;
        end else begin
          skip_nxt = skip_r + 1'b1;
        end
      end
      PH_HOST: begin
        if (data_byte == CHAR_SPACE || data_byte == CHAR_SLASH) begin
          phase_nxt = PH_REST;
        end else if (data_byte == CHAR_COLON) begin
          res.byte_role = ROLE_PORT;
          phase_nxt     = PH_PORT;
        end else begin
          res.byte_role      = ROLE_HOST;
          res.rewritten_byte = CHAR_SPACE;
        end
      end
      PH_PORT: begin
        if (is_digit) begin
          res.byte_role = ROLE_PORT;
          seen_nxt      = 1'b1;
          port_nxt      = (port_sum > 20'(PORT_MAX)) ? 16'(PORT_MAX) : port_sum[15:0];
        end else begin
          phase_nxt = PH_REST;
        end
      end
      default: begin
        res.byte_role = ROLE_REST;
      end
    endcase
    res.port_number = port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r <= PH_METHOD;
      skip_r  <= '0;
      port_r  <= 16'(PORT_DEFAULT);
      seen_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      port_r  <= port_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

@@ hw/rtl/prlr_kw_search.sv @@
module prlr_kw_search import prlr_pkg::*; #(
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  kw_cfg_t    cfg,
  output logic       hit
);

  localparam int LEN_W = $clog2(KEYWORD_MAX + 1);

  typedef enum logic [2:0] {
    GP_G0     = 3'd0,
    GP_G1     = 3'd1,
    GP_G2     = 3'd2,
    GP_G3     = 3'd3,
    GP_SKIPWS = 3'd4,
    GP_INURI  = 3'd5,
    GP_DONE   = 3'd6,
    GP_FAILED = 3'd7
  } gp_t;

  gp_t              gp_r, gp_nxt;
  logic [7:0]       win_r   [KEYWORD_MAX];
  logic [7:0]       win_nxt [KEYWORD_MAX];
  logic [7:0]       kb      [KEYWORD_MAX];
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             hit_r;

  logic             ws;
  logic             take;
  logic [7:0]       expect_ch;
  logic [LEN_W-1:0] len_eff;
  logic [KEYWORD_MAX-1:0] len_match;
  logic             sel_match;

  assign ws = (data_byte == 8'h20) || (data_byte == 8'h09) || (data_byte == 8'h0a)
           || (data_byte == 8'h0b) || (data_byte == 8'h0c) || (data_byte == 8'h0d);

  // "GET " prefix tracker, then whitespace skip and uri token
  always_comb begin
    gp_nxt    = gp_r;
    take      = 1'b0;
    expect_ch = 8'h47;
    case (gp_r)
      GP_G0: expect_ch = 8'h47;
      GP_G1: expect_ch = 8'h45;
      GP_G2: expect_ch = 8'h54;
      GP_G3: expect_ch = 8'h20;
      default: expect_ch = 8'h47;
    endcase
    case (gp_r)
      GP_G0, GP_G1, GP_G2, GP_G3: begin
        gp_nxt = (data_byte == expect_ch) ? gp_t'(gp_r + 3'd1) : GP_FAILED;
      end
      GP_SKIPWS: begin
        if (data_byte == 8'h00) begin
          gp_nxt = GP_DONE;
        end else if (!ws) begin
          gp_nxt = GP_INURI;
          take   = 1'b1;
        end
      end
      GP_INURI: begin
        if (data_byte == 8'h00 || ws) begin
          gp_nxt = GP_DONE;
        end else begin
          take = 1'b1;
        end
      end
      default: gp_nxt = gp_r;
    endcase
  end

  always_comb begin
    for (int i = 0; i < KEYWORD_MAX; i++) begin
      if (i < 8) begin
        kb[i] = 8'(cfg.first_bytes >> (8 * i));
      end else if (i == 8) begin
        kb[i] = cfg.ninth_byte;
      end else begin
        kb[i] = 8'd0;
      end
    end
  end

  always_comb begin
    if (cfg.length == 4'd0) begin
      len_eff = LEN_W'(1);
    end else if (5'(cfg.length) > 5'(KEYWORD_MAX)) begin
      len_eff = LEN_W'(KEYWORD_MAX);
    end else begin
      len_eff = LEN_W'(cfg.length);
    end
  end

  always_comb begin
    win_nxt[0] = data_byte;
    for (int i = 1; i < KEYWORD_MAX; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    cnt_nxt = (cnt_r == LEN_W'(KEYWORD_MAX)) ? cnt_r : cnt_r + 1'b1;
  end

  // one compare set per keyword length, newest byte is the last keyword byte
  always_comb begin
    for (int l = 0; l < KEYWORD_MAX; l++) begin
      len_match[l] = 1'b1;
      for (int i = 0; i < KEYWORD_MAX; i++) begin
        if (i <= l) begin
          if (win_nxt[l-i] != kb[i]) begin
            len_match[l] = 1'b0;
          end
        end
      end
    end
    sel_match = 1'b0;
    for (int l = 0; l < KEYWORD_MAX; l++) begin
      if (LEN_W'(l + 1) == len_eff) begin
        sel_match = len_match[l];
      end
    end
  end

  assign hit = hit_r || (take && (cnt_nxt >= len_eff) && sel_match);

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      gp_r  <= GP_G0;
      cnt_r <= '0;
      hit_r <= 1'b0;
      for (int i = 0; i < KEYWORD_MAX; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (step) begin
      gp_r  <= gp_nxt;
      hit_r <= hit;
      if (take) begin
        cnt_r <= cnt_nxt;
        for (int i = 0; i < KEYWORD_MAX; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

endmodule

@@ hw/rtl/proxy_request_line_rewriter.sv @@
// Proxy request line rewriter: one request byte in, one rewritten byte out. Each
// byte goes into an input register and is processed combinationally into the
// result register, so the block sustains one byte per clock while out_ready is
// high; out_valid rises when the result register is loaded, which is held off
// while a stalled result still occupies it. The method passes,
// the scheme prefix and the host become spaces, and the port digits after ':'
// are accumulated (80 when absent, saturating at 65535). For requests starting
// with "GET " the first URI token is searched for the keyword set through the
// register port (bytes at 0x00 and 0x08, length at 0x10); keyword_hit is sticky
// within a request. All parse state is cleared after the byte marked
// end_of_request. Registers should be written only while no request is in flight.
module proxy_request_line_rewriter import prlr_pkg::*; #(
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEF,
  parameter int SCHEME_SKIP = SCHEME_SKIP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_rewritten_byte,
  output logic [2:0]  out_byte_role,
  output logic        out_last_out,
  output logic [15:0] out_port_number,
  output logic        out_keyword_hit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  kw_cfg_t    cfg_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       step;
  logic       cfg_wr;
  parse_res_t pres;
  logic       hit;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  role_t       out_role_r;
  logic        out_last_r;
  logic [15:0] out_port_r;
  logic        out_hit_r;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_bytes <= 64'd0;
      cfg_r.ninth_byte  <= 8'd0;
      cfg_r.length      <= 4'd1;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_KW_FIRST:  cfg_r.first_bytes <= pwdata;
        REG_KW_NINTH:  cfg_r.ninth_byte  <= pwdata[7:0];
        REG_KW_LENGTH: cfg_r.length      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_KW_FIRST:  prdata = cfg_r.first_bytes;
      REG_KW_NINTH:  prdata = {56'd0, cfg_r.ninth_byte};
      REG_KW_LENGTH: prdata = {60'd0, cfg_r.length};
      default:       prdata = 64'd0;
    endcase
  end

  // input register, processed when the result register has room
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_end_of_request;
    end
  end

  prlr_line_parser #(
    .SCHEME_SKIP (SCHEME_SKIP)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .res       (pres)
  );

  prlr_kw_search #(
    .KEYWORD_MAX (KEYWORD_MAX)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .cfg       (cfg_r),
    .hit       (hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= pres.rewritten_byte;
      out_role_r <= pres.byte_role;
      out_last_r <= in_last_r;
      out_port_r <= pres.port_number;
      out_hit_r  <= hit;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rewritten_byte = out_byte_r;
  assign out_byte_role      = out_role_r;
  assign out_last_out       = out_last_r;
  assign out_port_number    = out_port_r;
  assign out_keyword_hit    = out_hit_r;

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is ready");

  a_blanked_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_role == ROLE_SCHEME || out_byte_role == ROLE_HOST)
      |-> out_rewritten_byte == CHAR_SPACE)
    else $error("scheme or host request byte not blanked");

  a_method_default_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_role == ROLE_METHOD |-> out_port_number == 16'(PORT_DEFAULT))
    else $error("port changed during method");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rewritten_byte))
    else $error("stalled result dropped or changed");
`endif

endmodule
